/* design/heightmap_box_blur_3x3_unit_defines.svh */
// ----------------------------------------------------------------------------
// heightmap_box_blur_3x3_unit_defines
// Assertion macros shared by the box blur unit.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BOX_BLUR_3X3_UNIT_DEFINES_SVH
`define HEIGHTMAP_BOX_BLUR_3X3_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HBB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("hbb assertion failed");

// next-cycle implication
`define HBB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("hbb assertion failed");

`else

`define HBB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define HBB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

/* design/hbb_pkg.sv */
// ----------------------------------------------------------------------------
// hbb_pkg
// Types and constants of the 3x3 heightmap box blur.
// ----------------------------------------------------------------------------
package hbb_pkg;

	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 4096;
	localparam int RESET_COLS = 128;
	localparam int RESET_ROWS = 128;

	localparam int COL_W    = 7;
	localparam int ROW_W    = 12;
	localparam int H_W      = 16;
	localparam int COLSUM_W = 18;
	localparam int SUM_W    = 20;
	localparam int MAG_W    = 19;
	localparam int PROD_W   = 2 * MAG_W;

	// floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT, exact for x < 2**21
	localparam int               DIV9_SHIFT = 22;
	localparam logic [MAG_W-1:0] DIV9_MUL   = MAG_W'(466034);

	localparam int GC_W       = 8;
	localparam int GR_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

	localparam int Q_DEPTH = 8;
	localparam int Q_IDX_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_IDX_W + 1;
	localparam int OCC_W   = Q_CNT_W + 1;

	typedef struct packed {
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic                  has_int;
		logic                  has_bord;
		logic                  done;
		logic signed [H_W-1:0] cur;
	} hbb_tag_t;

	typedef struct packed {
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
		logic                  has_int;
		logic                  has_bord;
		logic                  done;
		logic signed [H_W-1:0] int_val;
		logic signed [H_W-1:0] bord_val;
	} hbb_entry_t;

	typedef struct packed {
		logic       valid;
		hbb_entry_t entry;
	} hbb_push_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
		logic               empty;
	} hbb_qstat_t;

endpackage

/* design/hbb_if.sv */
// ----------------------------------------------------------------------------
// hbb_if
// Request channels of the box blur: samples in, filtered results out.
// ----------------------------------------------------------------------------
interface hbb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [hbb_pkg::H_W-1:0]    height_in;

	modport source(output valid, output height_in, input ready);
	modport sink(input valid, input height_in, output ready);
endinterface

interface hbb_out_if;
	logic                              valid;
	logic                              ready;
	logic [hbb_pkg::ROW_W-1:0]         out_row;
	logic [hbb_pkg::COL_W-1:0]         out_col;
	logic signed [hbb_pkg::H_W-1:0]    height_out;
	logic                              is_border;
	logic                              last_in_step;
	logic                              frame_done;

	modport source(output valid, output out_row, output out_col, output height_out,
		output is_border, output last_in_step, output frame_done, input ready);
	modport sink(input valid, input out_row, input out_col, input height_out,
		input is_border, input last_in_step, input frame_done, output ready);
endinterface

/* design/hbb_front.sv */
// ----------------------------------------------------------------------------
// hbb_front
// Raster position, two-row line store, column sums and the divide by nine.
// Classifies each sample and pushes one queue entry per sample with results.
// ----------------------------------------------------------------------------
module hbb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hbb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	hbb_in_if.sink                            samples,
	input  hbb_pkg::hbb_qstat_t               q_stat,
	output hbb_pkg::hbb_push_t                push
);
	import hbb_pkg::*;

	logic [COL_W-1:0] col_last_q, col_q, cols_last_new;
	logic [ROW_W-1:0] row_last_q, row_q, rows_last_new;
	logic [GC_W-1:0]  gc;
	logic [GR_W-1:0]  gr;
	logic             cfg_hit;
	logic             accept;
	logic [OCC_W-1:0] occ;

	logic signed [H_W-1:0] bank0_mem [MAX_COLS];
	logic signed [H_W-1:0] bank1_mem [MAX_COLS];

	logic                       valid_s1, valid_s2, valid_s3, valid_s4;
	hbb_tag_t                   tag_s1, tag_s2, tag_s3, tag_s4;
	logic                       bank_s1;
	logic signed [H_W-1:0]      rd0_s1, rd1_s1, top, mid;
	logic signed [COLSUM_W-1:0] colsum_s2, cs0_q, cs1_q;
	logic signed [SUM_W-1:0]    total_s3, mag_full;
	logic [MAG_W-1:0]           mag_s4;
	logic                       neg_s4;
	logic [PROD_W-1:0]          prod;
	logic [H_W-1:0]             quot;

	assign gc = cfg_data[GC_W-1:0];
	assign gr = cfg_data[GR_W-1:0];

	always_comb begin
		if (gc == '0) begin
			cols_last_new = '0;
		end else if (int'(gc) > MAX_COLS) begin
			cols_last_new = COL_W'(MAX_COLS - 1);
		end else begin
			cols_last_new = COL_W'(gc - GC_W'(1));
		end
		if (gr == '0) begin
			rows_last_new = '0;
		end else if (int'(gr) > MAX_ROWS) begin
			rows_last_new = ROW_W'(MAX_ROWS - 1);
		end else begin
			rows_last_new = ROW_W'(gr - GR_W'(1));
		end
	end

	assign cfg_hit = cfg_we && (cfg_idx == REG_GRID_COLS || cfg_idx == REG_GRID_ROWS);

	// room for every sample still in flight, counted as one entry each
	assign occ = OCC_W'(q_stat.count) + OCC_W'(valid_s1) + OCC_W'(valid_s2)
		+ OCC_W'(valid_s3) + OCC_W'(valid_s4);
	assign samples.ready = (occ < OCC_W'(Q_DEPTH));
	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_W'(RESET_COLS - 1);
			row_last_q <= ROW_W'(RESET_ROWS - 1);
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (cfg_hit) begin
				case (cfg_idx)
					REG_GRID_COLS: col_last_q <= cols_last_new;
					REG_GRID_ROWS: row_last_q <= rows_last_new;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_q == col_last_q) begin
					col_q <= '0;
					row_q <= (row_q == row_last_q) ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// line store: bank (row & 1) holds row r-2 at read time, then row r
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_s1 <= bank0_mem[col_q];
			rd1_s1 <= bank1_mem[col_q];
			if (row_q[0]) begin
				bank1_mem[col_q] <= samples.height_in;
			end else begin
				bank0_mem[col_q] <= samples.height_in;
			end
			bank_s1         <= row_q[0];
			tag_s1.row      <= row_q;
			tag_s1.col      <= col_q;
			tag_s1.has_int  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			tag_s1.has_bord <= (row_q == '0) || (row_q == row_last_q)
				|| (col_q == '0) || (col_q == col_last_q);
			tag_s1.done     <= (row_q == row_last_q) && (col_q == col_last_q);
			tag_s1.cur      <= samples.height_in;
		end
	end

	assign top = bank_s1 ? rd1_s1 : rd0_s1;
	assign mid = bank_s1 ? rd0_s1 : rd1_s1;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			colsum_s2 <= COLSUM_W'(top) + COLSUM_W'(mid) + COLSUM_W'(tag_s1.cur);
			tag_s2    <= tag_s1;
		end
		if (valid_s2) begin
			total_s3 <= SUM_W'(colsum_s2) + SUM_W'(cs1_q) + SUM_W'(cs0_q);
			cs0_q    <= cs1_q;
			cs1_q    <= colsum_s2;
			tag_s3   <= tag_s2;
		end
		if (valid_s3) begin
			mag_s4 <= mag_full[MAG_W-1:0];
			neg_s4 <= total_s3[SUM_W-1];
			tag_s4 <= tag_s3;
		end
	end

	// |sum| + 4, so floor((|sum| + 4) / 9) rounds to nearest
	assign mag_full = total_s3[SUM_W-1] ? (SUM_W'(4) - total_s3) : (total_s3 + SUM_W'(4));

	assign prod = PROD_W'(mag_s4) * PROD_W'(DIV9_MUL);
	assign quot = prod[DIV9_SHIFT +: H_W];

	always_comb begin
		push.valid          = valid_s4 && (tag_s4.has_int || tag_s4.has_bord);
		push.entry.row      = tag_s4.row;
		push.entry.col      = tag_s4.col;
		push.entry.has_int  = tag_s4.has_int;
		push.entry.has_bord = tag_s4.has_bord;
		push.entry.done     = tag_s4.done;
		push.entry.int_val  = neg_s4 ? H_W'(H_W'(0) - quot) : quot;
		push.entry.bord_val = tag_s4.cur;
	end

endmodule

/* design/hbb_queue.sv */
// ----------------------------------------------------------------------------
// hbb_queue
// Short FIFO of per-sample result entries between front and back.
// ----------------------------------------------------------------------------
module hbb_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hbb_pkg::hbb_push_t      push,
	input  logic                    pop,
	output hbb_pkg::hbb_entry_t     head,
	output hbb_pkg::hbb_qstat_t     q_stat
);
	import hbb_pkg::*;

	hbb_entry_t         entry_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + Q_IDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_IDX_W'(1);
			end
			count_q <= count_q + Q_CNT_W'(push.valid) - Q_CNT_W'(pop);
		end
	end

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.count = count_q;
	assign q_stat.empty = (count_q == '0);

endmodule

/* design/hbb_back.sv */
// ----------------------------------------------------------------------------
// hbb_back
// Splits each queue entry into its interior and border results and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module hbb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hbb_pkg::hbb_entry_t     head,
	input  hbb_pkg::hbb_qstat_t     q_stat,
	output logic                    pop,
	hbb_out_if.source               results
);
	import hbb_pkg::*;

	logic                  valid_q, second_q;
	logic                  load, pick_int, pick_last;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic signed [H_W-1:0] height_q;
	logic                  border_q, last_q, done_q;

	assign load      = !q_stat.empty && (!valid_q || results.ready);
	assign pick_int  = head.has_int && !second_q;
	assign pick_last = !pick_int || !head.has_bord;
	assign pop       = load && pick_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= !pick_last;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= pick_last;
			if (pick_int) begin
				row_q    <= head.row - ROW_W'(1);
				col_q    <= head.col - COL_W'(1);
				height_q <= head.int_val;
				border_q <= 1'b0;
				done_q   <= 1'b0;
			end else begin
				row_q    <= head.row;
				col_q    <= head.col;
				height_q <= head.bord_val;
				border_q <= 1'b1;
				done_q   <= head.done;
			end
		end
	end

	assign results.valid        = valid_q;
	assign results.out_row      = row_q;
	assign results.out_col      = col_q;
	assign results.height_out   = height_q;
	assign results.is_border    = border_q;
	assign results.last_in_step = last_q;
	assign results.frame_done   = done_q;

endmodule

/* design/heightmap_box_blur_3x3_unit.sv */
// ----------------------------------------------------------------------------
// heightmap_box_blur_3x3_unit
// 3x3 box blur over a raster stream of signed Q8.8 height samples.
//
//   channel   dir  payload                                   handshake
//   samples   in   height_in                                 valid/ready
//   results   out  out_row out_col height_out is_border      valid/ready
//                  last_in_step frame_done
//   cfg       in   cfg_idx cfg_data                          cfg_we
//
// One sample per cycle; a sample with both an interior and a border result
// holds the result channel for both, one after the other. A sample passes
// through line store read, column sum, window sum, magnitude, multiply into
// the queue and the output register. Samples stall only when the eight-entry
// queue cannot hold everything in flight. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "heightmap_box_blur_3x3_unit_defines.svh"

module heightmap_box_blur_3x3_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hbb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	hbb_in_if.sink                            samples,
	hbb_out_if.source                         results
);
	import hbb_pkg::*;

	hbb_push_t  push;
	hbb_entry_t head;
	hbb_qstat_t q_stat;
	logic       pop;

	hbb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.samples  (samples),
		.q_stat   (q_stat),
		.push     (push)
	);

	hbb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	hbb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

	`HBB_ASSERT_IMP(a_push_room, clk, arst_n, push.valid, q_stat.count < Q_CNT_W'(Q_DEPTH))
	`HBB_ASSERT_IMP(a_pop_nonempty, clk, arst_n, pop, !q_stat.empty)
	`HBB_ASSERT_NXT(a_pop_last, clk, arst_n, pop, results.valid && results.last_in_step)
	`HBB_ASSERT_IMP(a_done_border, clk, arst_n, results.valid && results.frame_done, results.is_border && results.last_in_step)

endmodule
